FILE: hdl/frame_sequencer_with_loop_fade_top_defines.svh
// ----------------------------------------------------------------------------
// Frame sequencer assertion macros
// Shared property wrappers, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_SEQUENCER_WITH_LOOP_FADE_TOP_DEFINES_SVH
`define FRAME_SEQUENCER_WITH_LOOP_FADE_TOP_DEFINES_SVH

// same-cycle implication
`define FSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/fsq_pkg.sv
// ----------------------------------------------------------------------------
// Frame sequencer package
// Event and action codes, request/result types and shared helpers.
// ----------------------------------------------------------------------------
package fsq_pkg;

   localparam int FUNC_W   = 3;
   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 5;
   localparam int DELAY_W  = 16;
   localparam int WAIT_W   = 14;
   localparam int STEP_W   = 3;
   localparam int CNT_W    = 6;
   localparam int FIDX_W   = 5;
   localparam int MIX_W    = 8;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PLAY  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PAUSE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd4;

   localparam logic [ACTION_W-1:0] ACT_SHOW  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BLEND = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [DELAY_W-1:0] MIN_FRAME_DELAY = 16'd50;
   localparam logic [WAIT_W-1:0]  MIN_BLEND_WAIT  = 14'd40;
   localparam logic [STEP_W-1:0]  BLEND_STEPS     = 3'd4;
   localparam logic [MIX_W-1:0]   MIX_FULL        = 8'd255;

   // x / 5 == (x * 0xCCCD) >> 18 for any 16-bit x
   localparam logic [DELAY_W-1:0] DIV5_MULT  = 16'hCCCD;
   localparam int                 DIV5_SHIFT = 18;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [31:0]        now_ms;
      logic [SLOT_W-1:0]  slot;
      logic [DELAY_W-1:0] delay_ms;
      logic               full_frame;
   } fsq_event_type;

   typedef struct packed {
      logic                valid;
      logic [ACTION_W-1:0] action;
      logic [FIDX_W-1:0]   frame_index;
      logic                clear_first;
      logic [MIX_W-1:0]    mix;
   } fsq_result_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  slot;
      logic [DELAY_W-1:0] delay_ms;
      logic               full_frame;
   } fsq_wr_type;

   typedef struct packed {
      logic [DELAY_W-1:0] delay;
      logic [WAIT_W-1:0]  fade_wait;
   } fsq_frame_type;

   function automatic logic [MIX_W-1:0] mix_of(input logic [STEP_W-1:0] step);
      logic [10:0] prod;
      prod = 11'(MIX_FULL) * 11'(step);
      return prod[9:2];
   endfunction

endpackage

FILE: hdl/fsq_table.sv
// ----------------------------------------------------------------------------
// Frame table
// Per-frame floored delay, fade step wait and full flag, computed on write.
// ----------------------------------------------------------------------------
module fsq_table #(
   parameter int MAX_FRAMES = 32
) (
   input  logic                                   clock,
   input  fsq_pkg::fsq_wr_type                    wr,
   input  logic [$clog2((MAX_FRAMES < 63) ? MAX_FRAMES : 63)-1:0] cur_idx,
   input  logic [$clog2((MAX_FRAMES < 63) ? MAX_FRAMES : 63)-1:0] next_idx,
   output fsq_pkg::fsq_frame_type                 cur_frame,
   output logic                                   next_full
);

   localparam int DEPTH = (MAX_FRAMES < 32) ? MAX_FRAMES : 32;
   localparam int AW    = $clog2(DEPTH);

   logic [fsq_pkg::DELAY_W-1:0] delay_ff [DEPTH];
   logic [fsq_pkg::WAIT_W-1:0]  wait_ff  [DEPTH];
   logic                        full_ff  [DEPTH];

   logic [fsq_pkg::DELAY_W-1:0] floored;
   logic [31:0]                 prod;
   logic [fsq_pkg::WAIT_W-1:0]  quo;
   logic [fsq_pkg::WAIT_W-1:0]  fade_wait;

   always_comb begin
      floored   = (wr.delay_ms < fsq_pkg::MIN_FRAME_DELAY) ? fsq_pkg::MIN_FRAME_DELAY
                                                           : wr.delay_ms;
      prod      = 32'(floored) * 32'(fsq_pkg::DIV5_MULT);
      quo       = prod[fsq_pkg::DIV5_SHIFT +: fsq_pkg::WAIT_W];
      fade_wait = (quo < fsq_pkg::MIN_BLEND_WAIT) ? fsq_pkg::MIN_BLEND_WAIT : quo;
   end

   always_ff @(posedge clock) begin
      if (wr.en && (32'(wr.slot) < DEPTH)) begin
         delay_ff[wr.slot[AW-1:0]] <= floored;
         wait_ff[wr.slot[AW-1:0]]  <= fade_wait;
         full_ff[wr.slot[AW-1:0]]  <= wr.full_frame;
      end
   end

   assign cur_frame.delay     = delay_ff[cur_idx[AW-1:0]];
   assign cur_frame.fade_wait = wait_ff[cur_idx[AW-1:0]];
   assign next_full           = full_ff[next_idx[AW-1:0]];

endmodule

FILE: hdl/fsq_core.sv
// ----------------------------------------------------------------------------
// Frame sequencer core
// Playback state and per-request decision: step, fade, stop, table write.
// ----------------------------------------------------------------------------
module fsq_core #(
   parameter int MAX_FRAMES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   fire,
   input  fsq_pkg::fsq_event_type                 evt,
   input  logic [fsq_pkg::CNT_W-1:0]              frame_count,
   input  fsq_pkg::fsq_frame_type                 cur_frame,
   input  logic                                   next_full,
   output logic [$clog2((MAX_FRAMES < 63) ? MAX_FRAMES : 63)-1:0] cur_idx,
   output logic [$clog2((MAX_FRAMES < 63) ? MAX_FRAMES : 63)-1:0] next_idx,
   output fsq_pkg::fsq_wr_type                    tbl_wr,
   output fsq_pkg::fsq_result_type                res
);

   localparam int CNT_MAX = (MAX_FRAMES < 63) ? MAX_FRAMES : 63;
   localparam int IDX_W   = $clog2(CNT_MAX);

   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [31:0]                 last_ff, last_in;
   logic                        playing_ff, playing_in;
   logic                        blending_ff, blending_in;
   logic [fsq_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [fsq_pkg::WAIT_W-1:0]  wait_ff, wait_in;

   logic [fsq_pkg::CNT_W-1:0]   count_eff;
   logic [31:0]                 elapsed;
   logic [fsq_pkg::STEP_W-1:0]  step_nxt;
   logic [IDX_W:0]              idx_plus1;

   assign cur_idx   = idx_ff;
   assign next_idx  = idx_ff + IDX_W'(1);
   assign idx_plus1 = {1'b0, idx_ff} + (IDX_W + 1)'(1);
   assign count_eff = (frame_count > fsq_pkg::CNT_W'(CNT_MAX)) ? fsq_pkg::CNT_W'(CNT_MAX)
                                                               : frame_count;
   assign elapsed   = evt.now_ms - last_ff;
   assign step_nxt  = step_ff + 3'd1;

   always_comb begin
      idx_in      = idx_ff;
      last_in     = last_ff;
      playing_in  = playing_ff;
      blending_in = blending_ff;
      step_in     = step_ff;
      wait_in     = wait_ff;
      res         = '0;
      res.action  = fsq_pkg::ACT_SHOW;
      tbl_wr.en         = 1'b0;
      tbl_wr.slot       = evt.slot;
      tbl_wr.delay_ms   = evt.delay_ms;
      tbl_wr.full_frame = evt.full_frame;
      unique case (evt.func)
         fsq_pkg::FUNC_TICK: begin
            if (playing_ff && (count_eff > 6'd1)) begin
               if (blending_ff) begin
                  if (elapsed >= 32'(wait_ff)) begin
                     last_in = evt.now_ms;
                     if (step_nxt > fsq_pkg::BLEND_STEPS) begin
                        blending_in = 1'b0;
                        step_in     = '0;
                        idx_in      = '0;
                     end else begin
                        step_in    = step_nxt;
                        res.valid  = 1'b1;
                        res.action = fsq_pkg::ACT_BLEND;
                        res.mix    = fsq_pkg::mix_of(step_nxt);
                     end
                  end
               end else if (elapsed >= 32'(cur_frame.delay)) begin
                  last_in   = evt.now_ms;
                  res.valid = 1'b1;
                  if (7'(idx_plus1) >= 7'(count_eff)) begin
                     blending_in = 1'b1;
                     step_in     = 3'd1;
                     wait_in     = cur_frame.fade_wait;
                     res.action  = fsq_pkg::ACT_BLEND;
                     res.mix     = fsq_pkg::mix_of(3'd1);
                  end else begin
                     idx_in          = next_idx;
                     res.frame_index = fsq_pkg::FIDX_W'(next_idx);
                     res.clear_first = (next_idx == '0) || next_full;
                  end
               end
            end
         end
         fsq_pkg::FUNC_PLAY: begin
            if (frame_count != '0) begin
               playing_in  = 1'b1;
               last_in     = evt.now_ms;
               blending_in = 1'b0;
               step_in     = '0;
            end
         end
         fsq_pkg::FUNC_PAUSE: begin
            if (frame_count != '0) begin
               playing_in = 1'b0;
            end
         end
         fsq_pkg::FUNC_STOP: begin
            if (frame_count != '0) begin
               playing_in  = 1'b0;
               idx_in      = '0;
               blending_in = 1'b0;
               step_in     = '0;
               res.valid   = 1'b1;
               res.action  = fsq_pkg::ACT_CLEAR;
            end
         end
         fsq_pkg::FUNC_WRITE: begin
            tbl_wr.en = fire;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         last_ff     <= '0;
         playing_ff  <= 1'b0;
         blending_ff <= 1'b0;
         step_ff     <= '0;
         wait_ff     <= '0;
      end else if (fire) begin
         idx_ff      <= idx_in;
         last_ff     <= last_in;
         playing_ff  <= playing_in;
         blending_ff <= blending_in;
         step_ff     <= step_in;
         wait_ff     <= wait_in;
      end
   end

endmodule

FILE: hdl/frame_sequencer_with_loop_fade_top.sv
// ----------------------------------------------------------------------------
// Frame sequencer with loop fade
// Steps an LED animation on tick requests and fades back to the first frame.
//
//   channel  direction  contents
//   req_*    in         event request: tuser func, tdata time/slot/delay/full
//   rsp_*    out        command: tuser action, tdata index/clear/mix
//   csr_*    in         frame_count write
//
// One request per cycle unless a command waits on a stalled result; a result
// passes the input register, then the result register (table read and compare).
// Synchronous reset clears playback state and frame_count; the frame table
// is not cleared. A stalled result holds in the result register; requests
// that produce no command keep passing, and the next one that produces a
// command waits in the input register with req_tready low.
// ----------------------------------------------------------------------------
module frame_sequencer_with_loop_fade_top #(
   parameter int MAX_FRAMES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] now_ms, [36:32] slot, [52:37] delay_ms, [53] full_frame, rest zero
   input  logic [fsq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] func
   input  logic [fsq_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [4:0] frame_index, [5] clear_first, [13:6] mix, rest zero
   output logic [fsq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [1:0] action
   output logic [fsq_pkg::ACTION_W-1:0]        rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [fsq_pkg::CNT_W-1:0]           csr_wr_data
);

   localparam int CNT_MAX = (MAX_FRAMES < 63) ? MAX_FRAMES : 63;
   localparam int IDX_W   = $clog2(CNT_MAX);

   logic                           in_valid_ff, in_valid_in;
   fsq_pkg::fsq_event_type         in_evt_ff;
   logic                           out_valid_ff, out_valid_in;
   fsq_pkg::fsq_result_type        out_res_ff;
   logic [fsq_pkg::CNT_W-1:0]      frame_count_ff;

   logic                           req_accept;
   logic                           fire;
   fsq_pkg::fsq_result_type        res;
   fsq_pkg::fsq_wr_type            tbl_wr;
   fsq_pkg::fsq_frame_type         cur_frame;
   logic                           next_full;
   logic [IDX_W-1:0]               cur_idx;
   logic [IDX_W-1:0]               next_idx;

   assign fire       = in_valid_ff && (!res.valid || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = (fire && res.valid) ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         frame_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_evt_ff.func       <= req_tuser;
         in_evt_ff.now_ms     <= req_tdata[31:0];
         in_evt_ff.slot       <= req_tdata[36:32];
         in_evt_ff.delay_ms   <= req_tdata[52:37];
         in_evt_ff.full_frame <= req_tdata[53];
      end
      if (fire && res.valid) begin
         out_res_ff <= res;
      end
   end

   fsq_core #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .evt         (in_evt_ff),
      .frame_count (frame_count_ff),
      .cur_frame   (cur_frame),
      .next_full   (next_full),
      .cur_idx     (cur_idx),
      .next_idx    (next_idx),
      .tbl_wr      (tbl_wr),
      .res         (res)
   );

   fsq_table #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_table (
      .clock     (clock),
      .wr        (tbl_wr),
      .cur_idx   (cur_idx),
      .next_idx  (next_idx),
      .cur_frame (cur_frame),
      .next_full (next_full)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.action;
   assign rsp_tdata  = {2'b00, out_res_ff.mix, out_res_ff.clear_first, out_res_ff.frame_index};

endmodule

FILE: hdl/fsq_checker.sv
// ----------------------------------------------------------------------------
// Frame sequencer port checker
// Watches the command channel for held stalls and consistent command fields.
// ----------------------------------------------------------------------------
`include "frame_sequencer_with_loop_fade_top_defines.svh"

module fsq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fsq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [fsq_pkg::ACTION_W-1:0]    rsp_tuser
);

   logic [fsq_pkg::RSP_TDATA_W+fsq_pkg::ACTION_W-1:0] rsp_word;
   logic                                              stalled;
   logic                                              is_blend;
   logic                                              is_show;
   logic                                              is_clear;
   logic                                              blend_ok;
   logic                                              show_ok;
   logic                                              clear_ok;

   assign rsp_word = {rsp_tuser, rsp_tdata};
   assign stalled  = rsp_tvalid && !rsp_tready;
   assign is_blend = rsp_tvalid && (rsp_tuser == fsq_pkg::ACT_BLEND);
   assign is_show  = rsp_tvalid && (rsp_tuser == fsq_pkg::ACT_SHOW);
   assign is_clear = rsp_tvalid && (rsp_tuser == fsq_pkg::ACT_CLEAR);
   assign blend_ok = (rsp_tdata[5:0] == 6'd0) && (rsp_tdata[7:6] == 2'b11) &&
                     (rsp_tdata[15:14] == 2'b00);
   assign show_ok  = (rsp_tdata[15:6] == 10'd0) && ((rsp_tdata[4:0] != 5'd0) || rsp_tdata[5]);
   assign clear_ok = (rsp_tdata == 16'd0);

   `FSQ_ASSERT_NEXT(a_rsp_hold, stalled, rsp_tvalid && $stable(rsp_word), "stalled command changed")

   `FSQ_ASSERT_IMPL(a_blend_fields, is_blend, blend_ok, "bad blend command")

   `FSQ_ASSERT_IMPL(a_show_fields, is_show, show_ok, "bad show command")

   `FSQ_ASSERT_IMPL(a_clear_fields, is_clear, clear_ok, "bad clear command")

endmodule

bind frame_sequencer_with_loop_fade_top fsq_checker u_fsq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/frame_sequencer_with_loop_fade_top_test.sv
// ----------------------------------------------------------------------------
// Frame sequencer with loop fade: stream-level test
// Drives play/pause/stop/tick/frame-write requests and frame_count settings,
// predicts every show, fade and clear command and checks each returned command
// field by field in order. A short directed table comes first, then random
// playback sessions under several frame counts with random gaps and stalls.
// ----------------------------------------------------------------------------
module frame_sequencer_with_loop_fade_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fsq_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 9;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int TABLE_DEPTH = 32;
   localparam int PHASE_ITEMS = 63;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [FIDX_W-1:0]   frame_index;
      logic                clear_first;
      logic [MIX_W-1:0]    mix;
   } panel_cmd_t;

   typedef enum {CHK_MODEL, CHK_NONE, CHK_CLEAR} chk_mode_e;

   typedef struct {
      bit            is_cfg;
      logic [5:0]    cfg;
      fsq_event_type ev;
      chk_mode_e     chk;
   } stim_row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]      req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [ACTION_W-1:0]    rsp_tuser;
   logic                   csr_wr_en = 1'b0;
   logic [CNT_W-1:0]       csr_wr_data = '0;

   frame_sequencer_with_loop_fade_top #(.MAX_FRAMES(TABLE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // predicted sequencer state
   logic [DELAY_W-1:0] seq_delay [TABLE_DEPTH];
   bit                 seq_full [TABLE_DEPTH];
   bit                 seq_written [TABLE_DEPTH];
   logic [CNT_W-1:0]   seq_count = '0;
   logic [FIDX_W-1:0]  seq_index = '0;
   logic [31:0]        seq_last = '0;
   bit                 seq_playing = 1'b0;
   bit                 seq_fading = 1'b0;
   logic [STEP_W-1:0]  seq_fade_step = '0;
   logic [WAIT_W-1:0]  seq_fade_wait = '0;

   panel_cmd_t pending_cmds[$];
   stim_row_t  dir_rows[$];
   logic [31:0] now_t = '0;
   bit quiet = 1'b0;
   int err_cnt = 0;
   int n_req = 0, n_show = 0, n_fade = 0, n_clear = 0, n_cfg = 0;
   int rdy_left = 0;
   int idle_cycles = 0;
   panel_cmd_t got_cmd, want_cmd;

   function automatic int unsigned floored_delay(input logic [FIDX_W-1:0] idx);
      int unsigned d;
      d = seq_delay[idx];
      return (d < MIN_FRAME_DELAY) ? MIN_FRAME_DELAY : d;
   endfunction

   function automatic logic [MIX_W-1:0] fade_mix(input logic [STEP_W-1:0] s);
      return MIX_W'((int'(MIX_FULL) * int'(s)) / int'(BLEND_STEPS));
   endfunction

   task automatic step_sequencer(input fsq_event_type ev, output bit produced,
                                 output panel_cmd_t cmd);
      int unsigned cnt, elapsed, fd;
      produced = 1'b0;
      cmd = '0;
      cnt = (seq_count > TABLE_DEPTH) ? TABLE_DEPTH : seq_count;
      case (ev.func)
         FUNC_TICK: begin
            elapsed = ev.now_ms - seq_last;
            if (seq_playing && cnt > 1) begin
               if (seq_fading) begin
                  if (elapsed >= seq_fade_wait) begin
                     seq_fade_step = seq_fade_step + 1'b1;
                     seq_last = ev.now_ms;
                     if (seq_fade_step > BLEND_STEPS) begin
                        seq_fading = 1'b0;
                        seq_fade_step = '0;
                        seq_index = '0;
                     end else begin
                        produced = 1'b1;
                        cmd.action = ACT_BLEND;
                        cmd.mix = fade_mix(seq_fade_step);
                     end
                  end
               end else begin
                  fd = floored_delay(seq_index);
                  if (elapsed >= fd) begin
                     seq_last = ev.now_ms;
                     produced = 1'b1;
                     if (int'(seq_index) + 1 >= int'(cnt)) begin
                        seq_fading = 1'b1;
                        seq_fade_step = 3'd1;
                        seq_fade_wait = WAIT_W'((fd / 5 < MIN_BLEND_WAIT) ? MIN_BLEND_WAIT
                                                                           : fd / 5);
                        cmd.action = ACT_BLEND;
                        cmd.mix = fade_mix(seq_fade_step);
                     end else begin
                        seq_index = seq_index + 1'b1;
                        cmd.action = ACT_SHOW;
                        cmd.frame_index = seq_index;
                        cmd.clear_first = (seq_index == 0) || seq_full[seq_index];
                     end
                  end
               end
            end
         end
         FUNC_PLAY: begin
            if (seq_count != 0) begin
               seq_playing = 1'b1;
               seq_last = ev.now_ms;
               seq_fading = 1'b0;
               seq_fade_step = '0;
            end
         end
         FUNC_PAUSE: begin
            if (seq_count != 0) seq_playing = 1'b0;
         end
         FUNC_STOP: begin
            if (seq_count != 0) begin
               seq_playing = 1'b0;
               seq_index = '0;
               seq_fading = 1'b0;
               seq_fade_step = '0;
               produced = 1'b1;
               cmd.action = ACT_CLEAR;
            end
         end
         FUNC_WRITE: begin
            seq_delay[ev.slot] = ev.delay_ms;
            seq_full[ev.slot] = ev.full_frame;
            seq_written[ev.slot] = 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic fsq_event_type next_random_event();
      fsq_event_type ev;
      int unsigned r, need, cnt;
      r = $urandom_range(0, 99);
      ev.now_ms = $urandom;
      ev.slot = $urandom_range(0, TABLE_DEPTH - 1);
      ev.full_frame = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: ev.delay_ms = $urandom_range(0, 120);
         7, 8: ev.delay_ms = $urandom_range(0, 16'hFFFF);
         default: ev.delay_ms = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
      endcase
      if (r < 60) begin
         ev.func = FUNC_TICK;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: now_t = now_t + $urandom_range(0, 150);
            5, 6, 7: begin
               if (seq_fading) need = seq_fade_wait;
               else if (seq_written[seq_index]) need = floored_delay(seq_index);
               else need = MIN_FRAME_DELAY;
               now_t = seq_last + need - $urandom_range(0, 1);
            end
            8: now_t = now_t + $urandom_range(0, 16'hFFFF);
            default: now_t = now_t + $urandom;
         endcase
         ev.now_ms = now_t;
      end else if (r < 75) begin
         ev.func = FUNC_WRITE;
      end else if (r < 80) begin
         ev.func = FUNC_PLAY;
         ev.now_ms = now_t;
      end else if (r < 84) begin
         ev.func = FUNC_PAUSE;
      end else if (r < 87) begin
         ev.func = FUNC_STOP;
      end else if (r < 92) begin
         ev.func = FUNC_W'($urandom_range(5, 7));
      end else begin
         ev.func = FUNC_TICK;
      end
      // never let a tick look up a frame entry that has not been loaded yet
      cnt = (seq_count > TABLE_DEPTH) ? TABLE_DEPTH : seq_count;
      if (ev.func == FUNC_TICK && seq_playing && cnt > 1 && !seq_fading) begin
         if (!seq_written[seq_index]) begin
            ev.func = FUNC_WRITE;
            ev.slot = seq_index;
         end else if (int'(seq_index) + 1 < int'(cnt) && !seq_written[seq_index + 1'b1]) begin
            ev.func = FUNC_WRITE;
            ev.slot = seq_index + 1'b1;
         end
      end
      return ev;
   endfunction

   task automatic send_request(input fsq_event_type ev, input chk_mode_e mode);
      bit produced;
      panel_cmd_t cmd;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, ev.full_frame, ev.delay_ms, ev.slot, ev.now_ms};
      req_tuser = ev.func;
      do @(posedge clock); while (!req_tready);
      n_req++;
      step_sequencer(ev, produced, cmd);
      case (mode)
         CHK_MODEL: if (produced) pending_cmds.push_back(cmd);
         CHK_CLEAR: pending_cmds.push_back('{ACT_CLEAR, '0, 1'b0, '0});
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_frame_count(input logic [CNT_W-1:0] value);
      drain();
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      seq_count = value;
      n_cfg++;
   endtask

   task automatic add_req(input logic [FUNC_W-1:0] func, input logic [31:0] now,
                          input logic [SLOT_W-1:0] slot, input logic [DELAY_W-1:0] dly,
                          input logic full, input chk_mode_e chk);
      stim_row_t row;
      row.is_cfg = 1'b0;
      row.cfg = '0;
      row.ev = '{func, now, slot, dly, full};
      row.chk = chk;
      dir_rows.push_back(row);
   endtask

   task automatic add_cfg(input logic [5:0] value);
      stim_row_t row;
      row.is_cfg = 1'b1;
      row.cfg = value;
      row.ev = '0;
      row.chk = CHK_NONE;
      dir_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_cmd = '{rsp_tuser, rsp_tdata[4:0], rsp_tdata[5], rsp_tdata[13:6]};
         if (pending_cmds.size() == 0) begin
            $error("unexpected command: action %0d, frame_index %0d, mix %0d",
                   got_cmd.action, got_cmd.frame_index, got_cmd.mix);
            err_cnt++;
         end else begin
            want_cmd = pending_cmds.pop_front();
            check_field("action", want_cmd.action, got_cmd.action);
            check_field("frame_index", want_cmd.frame_index, got_cmd.frame_index);
            check_field("clear_first", want_cmd.clear_first, got_cmd.clear_first);
            check_field("mix", want_cmd.mix, got_cmd.mix);
            case (want_cmd.action)
               ACT_SHOW: n_show++;
               ACT_BLEND: n_fade++;
               default: n_clear++;
            endcase
         end
      end
   end

   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_tready = 1'b1;
      end else if (rdy_left == 0) begin
         if ($urandom_range(0, 9) < 3) begin
            rsp_tready = 1'b0;
            rdy_left = $urandom_range(1, 9);
         end else begin
            rsp_tready = 1'b1;
            rdy_left = $urandom_range(1, 20);
         end
      end else begin
         rdy_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or command moved for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int counts[10];
      counts = '{32, 2, 63, 5, 1, 0, 17, 33, 3, 2};

      // nothing loaded: every request but a frame write is a no-op
      add_req(FUNC_TICK, 32'd0, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(FUNC_PLAY, 32'hFFFF_FFFF, 5'd31, 16'hFFFF, 1'b1, CHK_NONE);
      add_req(FUNC_STOP, 32'd0, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(FUNC_PAUSE, 32'd0, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(3'd5, 32'hFFFF_FFFF, 5'd31, 16'hFFFF, 1'b1, CHK_NONE);
      add_req(3'd7, 32'h5555_AAAA, 5'd10, 16'h5A5A, 1'b1, CHK_NONE);
      add_req(FUNC_WRITE, 32'd0, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(FUNC_WRITE, 32'd0, 5'd1, 16'hFFFF, 1'b1, CHK_NONE);
      add_req(FUNC_WRITE, 32'd0, 5'd2, 16'd100, 1'b0, CHK_NONE);
      add_req(FUNC_WRITE, 32'd0, 5'd31, 16'd49, 1'b1, CHK_NONE);
      add_cfg(6'd3);
      add_req(FUNC_PLAY, 32'd1000, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(FUNC_TICK, 32'd1049, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_TICK, 32'd1050, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_TICK, 32'd66585, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_TICK, 32'd66685, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_TICK, 32'd66725, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_TICK, 32'd66765, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_TICK, 32'd66805, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_TICK, 32'd66845, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      // elapsed time across the 32-bit wrap
      add_req(FUNC_PLAY, 32'hFFFF_FFF0, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(FUNC_TICK, 32'h0000_0022, 5'd0, 16'd0, 1'b0, CHK_MODEL);
      add_req(FUNC_STOP, 32'd0, 5'd0, 16'd0, 1'b0, CHK_CLEAR);
      // single frame: never steps
      add_cfg(6'd1);
      add_req(FUNC_PLAY, 32'd5, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(FUNC_TICK, 32'd10000, 5'd0, 16'd0, 1'b0, CHK_NONE);
      add_req(FUNC_PAUSE, 32'd0, 5'd0, 16'd0, 1'b0, CHK_NONE);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) write_frame_count(dir_rows[i].cfg);
         else send_request(dir_rows[i].ev, dir_rows[i].chk);
      end

      now_t = 32'd70000;
      foreach (counts[p]) begin
         write_frame_count(CNT_W'(counts[p]));
         if (p == $size(counts) - 1) quiet = 1'b1;
         send_request('{FUNC_PLAY, now_t, 5'd0, 16'd0, 1'b0}, CHK_MODEL);
         repeat (PHASE_ITEMS) send_request(next_random_event(), CHK_MODEL);
      end

      drain();
      repeat (4) @(posedge clock);
      $display("covered %0d requests over %0d frame_count settings", n_req, n_cfg);
      $display("commands checked: %0d show, %0d fade, %0d clear", n_show, n_fade, n_clear);
      if (err_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
